// ===== sv/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/mtt_pkg.sv =====
package mtt_pkg;

  // Command codes of an input item
  typedef enum logic [1:0] {
    CMD_WRITE_A = 2'd0,
    CMD_WRITE_B = 2'd1,
    CMD_READ    = 2'd2
  } cmd_t;

  // Configuration register indexes
  localparam logic [1:0] REG_ROWS_A    = 2'd0;
  localparam logic [1:0] REG_ROWS_B    = 2'd1;
  localparam logic [1:0] REG_INNER_LEN = 2'd2;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 5;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  // Sizes are compared in this width; maximum sizes go up to 256
  localparam int SIZE_W = 9;
  // Row times row length plus column, for any supported size
  localparam int LIN_W = 13;

  localparam int CMD_W       = 2;
  localparam int IDX_W       = 4;
  localparam int ELEM_W      = 16;
  localparam int PROD_W      = 32;
  localparam int PRODUCT_W   = 36;
  localparam int S_TDATA_W   = 32;
  localparam int M_TDATA_W   = 40;

  // Control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic issue;   // a pair of elements is read this cycle
    logic clear;   // start a new dot product
  } mac_ctrl_t;

endpackage

// ===== sv/mtt_store.sv =====
module mtt_store #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [mtt_pkg::ELEM_W-1:0] wr_data,
  input  logic [AW-1:0]              rd_addr,
  output logic [mtt_pkg::ELEM_W-1:0] rd_data
);
  import mtt_pkg::*;

  logic [ELEM_W-1:0] mem [DEPTH];

  // Write one element
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read with registered data
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/mtt_mac.sv =====
module mtt_mac #(
  parameter int ACC_W = 37
) (
  input  logic                       clk,
  input  logic                       rst,
  input  mtt_pkg::mac_ctrl_t         ctrl,
  input  logic [mtt_pkg::ELEM_W-1:0] a_data,
  input  logic [mtt_pkg::ELEM_W-1:0] b_data,
  output logic                       busy,
  output logic signed [ACC_W-1:0]    acc
);
  import mtt_pkg::*;

  logic                     data_valid;
  logic                     prod_valid;
  logic signed [PROD_W-1:0] prod;

  // Track element data arriving from the stores and the product register
  always_ff @(posedge clk) begin
    if (rst) begin
      data_valid <= 1'b0;
      prod_valid <= 1'b0;
    end else begin
      data_valid <= ctrl.issue;
      prod_valid <= data_valid;
    end
  end

  // Multiply one Q8.8 pair into Q16.16
  always_ff @(posedge clk) begin
    if (data_valid) begin
      prod <= signed'(a_data) * signed'(b_data);
    end
  end

  // Accumulate terms; clear starts a new sum
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  assign busy = data_valid | prod_valid;

endmodule

// ===== sv/matrix_times_transpose.sv =====
// Computes C = A * B^T on signed Q8.8 elements. Command 0 writes A[row][col], command 1
// writes B[row][col], each without a result; command 2 returns the Q20.16 dot product of
// A row 'row' with B row 'col' over inner_len terms (at most MAX_INNER), or zero with the
// error flag when row or col is outside the configured sizes. A read walks inner_len
// element pairs through a single multiply-accumulate unit at one term per cycle. Its result
// passes the memory read, multiply and accumulate registers, a wait in the drain state
// until the unit is idle, then the output register. The next item is taken in the cycle
// after the output register loads. A read that is out of range, or any read while
// inner_len is zero, goes straight to the output register. A previous result still
// waiting on m_tready holds a read in its last step. The block takes no item while a read
// is running. Elements never written must not be used by a read.
module matrix_times_transpose #(
  parameter int MAX_ROWS_A = 16,
  parameter int MAX_ROWS_B = 16,
  parameter int MAX_INNER  = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // command[1:0], row[5:2], col[9:6], value[25:10], zero fill
  input  logic [mtt_pkg::S_TDATA_W-1:0]  s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // product[35:0], zero fill
  output logic [mtt_pkg::M_TDATA_W-1:0]  m_tdata,
  // index_error[0]
  output logic                           m_tuser,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mtt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mtt_pkg::CFG_W-1:0]      cfg_data
);
  import mtt_pkg::*;

  localparam int A_DEPTH = MAX_ROWS_A * MAX_INNER;
  localparam int B_DEPTH = MAX_ROWS_B * MAX_INNER;
  localparam int A_AW    = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
  localparam int B_AW    = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
  localparam int CNT_W   = $clog2(MAX_INNER + 1);
  localparam int ACC_W   = PROD_W + $clog2(MAX_INNER + 1);
  localparam int EXT_W   = (ACC_W > PRODUCT_W) ? ACC_W : PRODUCT_W;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_RUN    = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [CFG_W-1:0]  rows_a, rows_b, inner_len;
  logic [SIZE_W-1:0] ra, rb, nk;

  cmd_t              cmd;
  logic [IDX_W-1:0]  row, col;
  logic [ELEM_W-1:0] value;
  logic              accept;
  logic              row_a_ok, row_b_ok, col_nk_ok, col_b_ok;
  logic [LIN_W-1:0]  row_base, col_base, wr_lin;

  logic              wr_a_en, wr_b_en;
  logic [A_AW-1:0]   a_addr;
  logic [B_AW-1:0]   b_addr;
  logic [CNT_W-1:0]  cnt;
  logic              err;

  logic [ELEM_W-1:0] a_data, b_data;
  mac_ctrl_t         mac_ctrl;
  logic              mac_busy;
  logic signed [ACC_W-1:0] acc;
  logic signed [EXT_W-1:0] acc_ext;
  logic              out_load;

  // Take configuration writes at any time
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a    <= CFG_RESET;
      rows_b    <= CFG_RESET;
      inner_len <= CFG_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ROWS_A:    rows_a    <= cfg_data;
        REG_ROWS_B:    rows_b    <= cfg_data;
        REG_INNER_LEN: inner_len <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp sizes to the store dimensions
  always_comb begin
    ra = (SIZE_W'(rows_a) > SIZE_W'(MAX_ROWS_A)) ? SIZE_W'(MAX_ROWS_A) : SIZE_W'(rows_a);
    rb = (SIZE_W'(rows_b) > SIZE_W'(MAX_ROWS_B)) ? SIZE_W'(MAX_ROWS_B) : SIZE_W'(rows_b);
    nk = (SIZE_W'(inner_len) > SIZE_W'(MAX_INNER)) ? SIZE_W'(MAX_INNER)
                                                   : SIZE_W'(inner_len);
  end

  // Unpack the input item
  assign cmd    = cmd_t'(s_tdata[CMD_W-1:0]);
  assign row    = s_tdata[CMD_W +: IDX_W];
  assign col    = s_tdata[CMD_W+IDX_W +: IDX_W];
  assign value  = s_tdata[CMD_W+2*IDX_W +: ELEM_W];
  assign accept = s_tvalid & s_tready;

  assign row_a_ok  = SIZE_W'(row) < ra;
  assign row_b_ok  = SIZE_W'(row) < rb;
  assign col_nk_ok = SIZE_W'(col) < nk;
  assign col_b_ok  = SIZE_W'(col) < rb;

  // Linear addresses: row times row length, plus column for writes
  assign row_base = LIN_W'(row) * LIN_W'(MAX_INNER);
  assign col_base = LIN_W'(col) * LIN_W'(MAX_INNER);
  assign wr_lin   = row_base + LIN_W'(col);

  // Decode writes in the idle state
  always_comb begin
    wr_a_en = 1'b0;
    wr_b_en = 1'b0;
    if (accept) begin
      case (cmd)
        CMD_WRITE_A: wr_a_en = row_a_ok & col_nk_ok;
        CMD_WRITE_B: wr_b_en = row_b_ok & col_nk_ok;
        default: ;
      endcase
    end
  end

  assign s_tready      = (state == ST_IDLE);
  assign mac_ctrl.clear = accept && (cmd == CMD_READ);
  assign mac_ctrl.issue = (state == ST_RUN);
  assign out_load       = (state == ST_FINISH) && (!m_tvalid || m_tready);

  // Sequence a read
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && cmd == CMD_READ) begin
          if (!row_a_ok || !col_b_ok || nk == '0) begin
            state_next = ST_FINISH;
          end else begin
            state_next = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (cnt == CNT_W'(1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!mac_busy) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Load read addresses and count terms
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept && cmd == CMD_READ) begin
      a_addr <= A_AW'(row_base);
      b_addr <= B_AW'(col_base);
      cnt    <= CNT_W'(nk);
      err    <= !row_a_ok || !col_b_ok;
    end else if (state == ST_RUN) begin
      a_addr <= a_addr + A_AW'(1);
      b_addr <= b_addr + B_AW'(1);
      cnt    <= cnt - CNT_W'(1);
    end
  end

  mtt_store #(
    .DEPTH (A_DEPTH),
    .AW    (A_AW)
  ) u_a_store (
    .clk     (clk),
    .wr_en   (wr_a_en),
    .wr_addr (A_AW'(wr_lin)),
    .wr_data (value),
    .rd_addr (a_addr),
    .rd_data (a_data)
  );

  mtt_store #(
    .DEPTH (B_DEPTH),
    .AW    (B_AW)
  ) u_b_store (
    .clk     (clk),
    .wr_en   (wr_b_en),
    .wr_addr (B_AW'(wr_lin)),
    .wr_data (value),
    .rd_addr (b_addr),
    .rd_data (b_data)
  );

  mtt_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (mac_ctrl),
    .a_data (a_data),
    .b_data (b_data),
    .busy   (mac_busy),
    .acc    (acc)
  );

  assign acc_ext = EXT_W'(acc);

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= err ? '0 : M_TDATA_W'(acc_ext[PRODUCT_W-1:0]);
      m_tuser <= err;
    end
  end

endmodule

// ===== sv/mtt_check.sv =====
`include "assert_macros.svh"

module mtt_check (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic [mtt_pkg::S_TDATA_W-1:0]  s_tdata,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [mtt_pkg::M_TDATA_W-1:0]  m_tdata,
  input logic                           m_tuser
);
  import mtt_pkg::*;

  // An index error carries a zero product
  `ASSERT_SAME(err_zero, clk, rst, m_tvalid && m_tuser, m_tdata == '0, "error result not zero")

  // Fill bits above the product stay zero
  `ASSERT_SAME(fill_zero, clk, rst, m_tvalid, m_tdata[M_TDATA_W-1:PRODUCT_W] == '0, "fill bits set")

  // A read holds off the next item
  `ASSERT_NEXT(read_busy, clk, rst, s_tvalid && s_tready && s_tdata[CMD_W-1:0] == CMD_READ, !s_tready, "ready after read")

  // A stalled result holds
  `ASSERT_NEXT(out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind matrix_times_transpose mtt_check u_mtt_check (.*);
